### rtl/fjs_pkg.sv
// Shared constants and types for the FIFO job server tick block.
// No dependencies; imported by every RTL module of the block except fjs_ram.
`default_nettype none

package fjs_pkg;

    // Parameter defaults
    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int DURATION_BITS_DEF = 8;

    // Fixed field widths
    localparam int ID_W     = 16;
    localparam int TICK_W   = 32;
    localparam int SERVED_W = 32;
    localparam int WAIT_W   = 40;

    // Server to queue control
    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    // Queue to server status
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

### rtl/fjs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing; used for the job queue storage.
`default_nettype none

module fjs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port, read-before-write on a shared address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/fjs_queue.sv
// Job queue: circular buffer in RAM with a head entry always presented.
// Depends on fjs_pkg and fjs_ram.
`default_nettype none

module fjs_queue #(
    parameter int DEPTH = 16,
    parameter int ENT_W = 56
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_adv,
    input  wire fjs_pkg::t_q_ctrl           i_ctrl,
    input  wire logic [ENT_W-1:0]           i_push_entry,
    output fjs_pkg::t_q_stat                o_stat,
    output logic      [ENT_W-1:0]           o_head_entry,
    output logic      [$clog2(DEPTH+1)-1:0] o_occ_next
);

    import fjs_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_occ, n_occ;
    logic             r_byp_hit;
    logic [ENT_W-1:0] r_byp_data;
    logic [ENT_W-1:0] w_rdata;
    logic             w_we;
    logic             w_pop;

    function automatic logic [PTR_W-1:0] f_inc(input logic [PTR_W-1:0] p);
        f_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign w_we  = i_adv && i_ctrl.push;
    assign w_pop = i_adv && i_ctrl.pop;

    // Pointer and occupancy update
    always_comb begin
        n_head = w_pop ? f_inc(r_head) : r_head;
        n_tail = w_we ? f_inc(r_tail) : r_tail;
        n_occ  = r_occ;
        case ({w_we, w_pop})
            2'b10:   n_occ = r_occ + CNT_W'(1);
            2'b01:   n_occ = r_occ - CNT_W'(1);
            default: n_occ = r_occ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_occ     <= '0;
            r_byp_hit <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_occ     <= n_occ;
            r_byp_hit <= w_we && (r_tail == n_head);
        end
    end

    // Write data kept for a same-slot write/read collision
    always_ff @(posedge i_clk) begin
        r_byp_data <= i_push_entry;
    end

    // Storage, read address is the next head so the registered read presents the head
    fjs_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_tail),
        .i_wdata (i_push_entry),
        .i_raddr (n_head),
        .o_rdata (w_rdata)
    );

    assign o_head_entry = r_byp_hit ? r_byp_data : w_rdata;
    assign o_stat.full  = (r_occ == CNT_W'(DEPTH));
    assign o_stat.empty = (r_occ == '0);
    assign o_occ_next   = n_occ;

endmodule

`default_nettype wire

### rtl/fjs_server.sv
// Server and bookkeeping for one tick: id issue, drop, start, countdown, stats.
// Depends on fjs_pkg; drives the queue control of fjs_queue.
`default_nettype none

module fjs_server #(
    parameter int DURATION_BITS = 8
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_adv,
    input  wire logic                                   i_arrives,
    input  wire logic [DURATION_BITS-1:0]               i_duration,
    input  wire fjs_pkg::t_q_stat                       i_q_stat,
    input  wire logic [DURATION_BITS+fjs_pkg::TICK_W+fjs_pkg::ID_W-1:0] i_head_entry,
    output fjs_pkg::t_q_ctrl                            o_q_ctrl,
    output logic [DURATION_BITS+fjs_pkg::TICK_W+fjs_pkg::ID_W-1:0] o_push_entry,
    output logic                                        o_dropped,
    output logic                                        o_started,
    output logic [fjs_pkg::ID_W-1:0]                    o_serving_id,
    output logic [DURATION_BITS-1:0]                    o_ticks_left,
    output logic [fjs_pkg::SERVED_W-1:0]                o_served,
    output logic [fjs_pkg::WAIT_W-1:0]                  o_wait_total
);

    import fjs_pkg::*;

    localparam int DB    = DURATION_BITS;
    localparam int ENT_W = DB + TICK_W + ID_W;

    logic [TICK_W-1:0]   r_tick;
    logic [ID_W-1:0]     r_last_id, n_last_id;
    logic [ID_W-1:0]     r_active, n_active;
    logic [DB-1:0]       r_rem, n_rem;
    logic [SERVED_W-1:0] r_served, n_served;
    logic [WAIT_W-1:0]   r_wait, n_wait;

    logic                w_push, w_start;
    logic [ENT_W-1:0]    w_ent;
    logic [ID_W-1:0]     w_ent_id;
    logic [TICK_W-1:0]   w_ent_arr;
    logic [DB-1:0]       w_ent_dur;
    logic [TICK_W-1:0]   w_wait;
    logic [WAIT_W:0]     w_sum;

    // Arrival: id is consumed even when the job is dropped
    assign n_last_id    = i_arrives ? r_last_id + ID_W'(1) : r_last_id;
    assign w_push       = i_arrives && !i_q_stat.full;
    assign o_push_entry = {i_duration, r_tick, n_last_id};

    // Start when idle and a job is waiting, including one that just arrived
    assign w_start = (r_rem == '0) && (!i_q_stat.empty || w_push);
    assign w_ent   = i_q_stat.empty ? o_push_entry : i_head_entry;

    assign w_ent_id  = w_ent[ID_W-1:0];
    assign w_ent_arr = w_ent[ID_W +: TICK_W];
    assign w_ent_dur = w_ent[ID_W + TICK_W +: DB];

    // Queue wait, summed with saturation
    assign w_wait = r_tick - w_ent_arr;
    assign w_sum  = {1'b0, r_wait} + (WAIT_W + 1)'(w_wait);

    always_comb begin
        n_active = r_active;
        n_served = r_served;
        n_wait   = r_wait;
        if (w_start) begin
            n_active = w_ent_id;
            n_rem    = (w_ent_dur == '0) ? '0 : w_ent_dur - DB'(1);
            n_served = r_served + SERVED_W'(1);
            n_wait   = w_sum[WAIT_W] ? '1 : w_sum[WAIT_W-1:0];
        end else if (r_rem != '0) begin
            n_rem = r_rem - DB'(1);
        end else begin
            n_rem = r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick    <= '0;
            r_last_id <= '0;
            r_active  <= '0;
            r_rem     <= '0;
            r_served  <= '0;
            r_wait    <= '0;
        end else if (i_adv) begin
            r_tick    <= r_tick + TICK_W'(1);
            r_last_id <= n_last_id;
            r_active  <= n_active;
            r_rem     <= n_rem;
            r_served  <= n_served;
            r_wait    <= n_wait;
        end
    end

    // A start always takes the head slot; on an empty queue that is the slot pushed now
    assign o_q_ctrl.push = w_push;
    assign o_q_ctrl.pop  = w_start;
    assign o_dropped     = i_arrives && i_q_stat.full;
    assign o_started     = w_start;
    assign o_serving_id  = n_active;
    assign o_ticks_left  = n_rem;
    assign o_served      = n_served;
    assign o_wait_total  = n_wait;

endmodule

`default_nettype wire

### rtl/fifo_job_server_tick_top.sv
// Top level of the FIFO job server tick block: stream ports, input and result registers.
// Depends on fjs_pkg, fjs_queue and fjs_server.
`default_nettype none

// One input transfer is one time tick; every tick gives exactly one result transfer.
// The block takes one tick per clock, sustained, while results are taken. An accepted
// tick is held in the input register, then goes in a single pass through the queue and
// server logic into the result register, from which its result is offered; while the
// result register is stalled, the tick waits in the input register. The queue RAM
// presents its head entry every cycle through a registered read addressed at the next
// head. The queue storage needs no clearing after reset, so the block is ready at once.
// A job arriving into a full queue is dropped and flagged; the wait total saturates at
// its maximum.
module fifo_job_server_tick_top #(
    parameter int QUEUE_DEPTH   = fjs_pkg::QUEUE_DEPTH_DEF,
    parameter int DURATION_BITS = fjs_pkg::DURATION_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    // s_axis_tdata, low bit up: job_arrives, job_duration, zero fill
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    input  wire logic [((1 + DURATION_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // m_axis_tdata, low bit up: job_dropped, job_started, serving_id, ticks_left,
    // queued_count, jobs_served, wait_total, zero fill
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    output logic [((2 + fjs_pkg::ID_W + DURATION_BITS + $clog2(QUEUE_DEPTH + 1)
                   + fjs_pkg::SERVED_W + fjs_pkg::WAIT_W + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    import fjs_pkg::*;

    localparam int DB      = DURATION_BITS;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W   = DB + TICK_W + ID_W;
    localparam int OUT_RAW = 2 + ID_W + DB + CNT_W + SERVED_W + WAIT_W;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    logic             r_in_valid;
    logic             r_in_arrives;
    logic [DB-1:0]    r_in_dur;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data, n_out_data;
    logic             w_adv;

    t_q_ctrl             w_q_ctrl;
    t_q_stat             w_q_stat;
    logic [ENT_W-1:0]    w_head_entry;
    logic [ENT_W-1:0]    w_push_entry;
    logic [CNT_W-1:0]    w_occ_next;
    logic                w_dropped, w_started;
    logic [ID_W-1:0]     w_serving_id;
    logic [DB-1:0]       w_ticks_left;
    logic [SERVED_W-1:0] w_served;
    logic [WAIT_W-1:0]   w_wait_total;

    // Tick in the input register is processed when the result register can take it
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_arrives <= s_axis_tdata[0];
            r_in_dur     <= s_axis_tdata[DB:1];
        end
    end

    fjs_queue #(
        .DEPTH (QUEUE_DEPTH),
        .ENT_W (ENT_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_ctrl       (w_q_ctrl),
        .i_push_entry (w_push_entry),
        .o_stat       (w_q_stat),
        .o_head_entry (w_head_entry),
        .o_occ_next   (w_occ_next)
    );

    fjs_server #(
        .DURATION_BITS (DB)
    ) u_server (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_arrives    (r_in_arrives),
        .i_duration   (r_in_dur),
        .i_q_stat     (w_q_stat),
        .i_head_entry (w_head_entry),
        .o_q_ctrl     (w_q_ctrl),
        .o_push_entry (w_push_entry),
        .o_dropped    (w_dropped),
        .o_started    (w_started),
        .o_serving_id (w_serving_id),
        .o_ticks_left (w_ticks_left),
        .o_served     (w_served),
        .o_wait_total (w_wait_total)
    );

    // Result packing
    always_comb begin
        n_out_data = '0;
        n_out_data[OUT_RAW-1:0] = {w_wait_total, w_served, w_occ_next, w_ticks_left,
                                   w_serving_id, w_started, w_dropped};
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

### rtl/fjs_checker.sv
// Port-level checker for the FIFO job server tick block, bound to the top level.
// Depends on fjs_pkg and fifo_job_server_tick_top.
`default_nettype none

module fjs_checker #(
    parameter int QUEUE_DEPTH   = fjs_pkg::QUEUE_DEPTH_DEF,
    parameter int DURATION_BITS = fjs_pkg::DURATION_BITS_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic [((2 + fjs_pkg::ID_W + DURATION_BITS + $clog2(QUEUE_DEPTH + 1)
                       + fjs_pkg::SERVED_W + fjs_pkg::WAIT_W + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    import fjs_pkg::*;

    localparam int DB      = DURATION_BITS;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int LEFT_LO = 2 + ID_W;
    localparam int CNT_LO  = LEFT_LO + DB;
    localparam int SRV_LO  = CNT_LO + CNT_W;

    logic                w_xfer;
    logic                w_dropped, w_started;
    logic [DB-1:0]       w_left;
    logic [CNT_W-1:0]    w_count;
    logic [SERVED_W-1:0] w_served;
    logic                r_seen;
    logic [DB-1:0]       r_prev_left;
    logic [SERVED_W-1:0] r_prev_served;

    assign w_xfer    = m_axis_tvalid && m_axis_tready;
    assign w_dropped = m_axis_tdata[0];
    assign w_started = m_axis_tdata[1];
    assign w_left    = m_axis_tdata[LEFT_LO +: DB];
    assign w_count   = m_axis_tdata[CNT_LO +: CNT_W];
    assign w_served  = m_axis_tdata[SRV_LO +: SERVED_W];

    // Last result transfer seen
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (w_xfer) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_xfer) begin
            r_prev_left   <= w_left;
            r_prev_served <= w_served;
        end
    end

    // A busy server only counts down and starts nothing
    a_countdown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_xfer && r_seen && (r_prev_left != '0)) |->
            (!w_started && (w_left == r_prev_left - DB'(1))))
        else $error("busy server did not count down by one");

    // Served count rises by exactly the start flag
    a_served: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_xfer && r_seen) |-> (w_served == r_prev_served + SERVED_W'(w_started)))
        else $error("served count out of step with start flag");

    // A drop happens only with the queue full or just drained by one
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_dropped) |-> (w_count >= CNT_W'(QUEUE_DEPTH - 1)))
        else $error("job dropped while queue had room");

    // A stalled result holds its data
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // Reset leaves no result pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind fifo_job_server_tick_top fjs_checker #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .DURATION_BITS (DURATION_BITS)
) u_fjs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
